>>> src/sst_pkg.sv
// Shared types, constants and codes for the sorted set table.
// Used by sst_ctrl, sst_dp and sorted_set_table; depends on nothing else.
package sst_pkg;

    // Store geometry.
    localparam int DEPTH     = 64;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // Configuration register.
    localparam logic [6:0] CAP_RESET   = 7'd64;
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    // Operation codes.
    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_ERASE  = 3'd1;
    localparam logic [2:0] FUNC_FIND   = 3'd2;
    localparam logic [2:0] FUNC_ACCESS = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef logic [KEY_WIDTH-1:0] key_t;

    // Input word.
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] key;
        logic [5:0]  slot;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [6:0]  position;
        logic [31:0] data;
        logic [6:0]  count;
    } out_word_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PLACE,
        S_ACC_RD,
        S_FINISH
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_cmp;
        logic shift_init;
        logic shift_rd;
        logic shift_wr;
        logic place;
        logic acc_rd;
        logic finish;
    } ctrl_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_insert;
        logic is_erase;
        logic is_find;
        logic is_access;
        logic full;
        logic slot_ok;
        logic lo_lt_hi;
        logic eq;
        logic shift_more;
        logic out_free;
    } ctrl_sts_t;

endpackage

>>> src/sst_ctrl.sv
// Controller state machine of the sorted set table.
// Depends on sst_pkg; drives commands into sst_dp and reads its status.
module sst_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sst_pkg::ctrl_sts_t sts,
    output sst_pkg::ctrl_cmd_t cmd
);
    import sst_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (sts.is_insert) begin
                    state_next = sts.full ? S_FINISH : S_SRCH_RD;
                end else if (sts.is_erase || sts.is_find) begin
                    state_next = S_SRCH_RD;
                end else if (sts.is_access && sts.slot_ok) begin
                    state_next = S_ACC_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SRCH_RD: begin
                state_next = sts.lo_lt_hi ? S_SRCH_CMP : S_DECIDE;
            end
            S_SRCH_CMP: begin
                state_next = S_SRCH_RD;
            end
            S_DECIDE: begin
                if ((sts.is_insert && !sts.eq) || (sts.is_erase && sts.eq)) begin
                    state_next = S_SHIFT_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_RD: begin
                if (sts.shift_more) begin
                    state_next = S_SHIFT_WR;
                end else if (sts.is_insert) begin
                    state_next = S_PLACE;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_WR: begin
                state_next = S_SHIFT_RD;
            end
            S_PLACE: begin
                state_next = S_FINISH;
            end
            S_ACC_RD: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_DISPATCH: begin
            end
            S_SRCH_RD: begin
                cmd.srch_rd = sts.lo_lt_hi;
            end
            S_SRCH_CMP: begin
                cmd.srch_cmp = 1'b1;
            end
            S_DECIDE: begin
                cmd.shift_init = (sts.is_insert && !sts.eq) || (sts.is_erase && sts.eq);
            end
            S_SHIFT_RD: begin
                cmd.shift_rd = sts.shift_more;
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
            end
            S_PLACE: begin
                cmd.place = 1'b1;
            end
            S_ACC_RD: begin
                cmd.acc_rd = 1'b1;
            end
            S_FINISH: begin
                cmd.finish = sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> src/sst_dp.sv
// Datapath of the sorted set table: key store, search bounds, shift pointer,
// key count and result register. Depends on sst_pkg; driven by sst_ctrl.
module sst_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  sst_pkg::in_word_t   s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output sst_pkg::out_word_t  m_word,
    input  logic [6:0]          capacity,
    input  sst_pkg::ctrl_cmd_t  cmd,
    output sst_pkg::ctrl_sts_t  sts
);
    import sst_pkg::*;

    // Key store with one write and one registered read port.
    key_t entry_mem [DEPTH];
    key_t rdata_reg;

    logic [2:0]       func_reg;
    key_t             key_reg;
    logic [5:0]       slot_reg;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic             eq_reg, eq_next;
    logic             full_reg;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        out_reg, out_next;

    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic [CNT_W-1:0] ptr_dn;
    logic [CNT_W-1:0] ptr_up;
    logic             is_insert, is_erase, is_find, is_access, is_clear;
    logic             slot_ok;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    key_t             mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    // Operation decode and simple comparisons.
    always_comb begin
        is_insert = (func_reg == FUNC_INSERT);
        is_erase  = (func_reg == FUNC_ERASE);
        is_find   = (func_reg == FUNC_FIND);
        is_access = (func_reg == FUNC_ACCESS);
        is_clear  = (func_reg == FUNC_CLEAR);
        slot_ok   = ({{(CNT_W + 1){1'b0}}, slot_reg} < {{7{1'b0}}, held_reg});
        if (int'(capacity) > DEPTH) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(capacity);
        end
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid     = mid_sum[IDX_W:1];
        ptr_dn  = ptr_reg - CNT_W'(1);
        ptr_up  = ptr_reg + CNT_W'(1);
    end

    // Status toward the controller.
    always_comb begin
        sts.is_insert  = is_insert;
        sts.is_erase   = is_erase;
        sts.is_find    = is_find;
        sts.is_access  = is_access;
        sts.full       = full_reg;
        sts.slot_ok    = slot_ok;
        sts.lo_lt_hi   = (lo_reg < hi_reg);
        sts.eq         = eq_reg;
        sts.shift_more = is_insert ? (ptr_reg > hi_reg)
                                   : (({1'b0, ptr_reg} + (CNT_W + 1)'(1))
                                      < {1'b0, held_reg});
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // Store port selection.
    always_comb begin
        mem_re    = cmd.srch_rd || cmd.shift_rd || cmd.acc_rd;
        mem_raddr = mid;
        if (cmd.shift_rd) begin
            mem_raddr = is_insert ? ptr_dn[IDX_W-1:0] : ptr_up[IDX_W-1:0];
        end else if (cmd.acc_rd) begin
            mem_raddr = IDX_W'(slot_reg);
        end
        mem_we    = cmd.shift_wr || cmd.place;
        mem_waddr = cmd.place ? hi_reg[IDX_W-1:0] : ptr_reg[IDX_W-1:0];
        mem_wdata = cmd.place ? key_reg : rdata_reg;
    end

    // Key store.
    always_ff @(posedge aclk) begin
        if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
        if (mem_re) rdata_reg <= entry_mem[mem_raddr];
    end

    // Search bounds, shift pointer, count and result.
    always_comb begin
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        eq_next      = eq_reg;
        ptr_next     = ptr_reg;
        held_next    = held_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cmd.load) begin
            lo_next = '0;
            hi_next = held_reg;
            eq_next = 1'b0;
        end
        if (cmd.srch_cmp) begin
            if (rdata_reg < key_reg) begin
                lo_next = CNT_W'(mid) + CNT_W'(1);
            end else begin
                hi_next = CNT_W'(mid);
                eq_next = (rdata_reg == key_reg);
            end
        end
        if (cmd.shift_init) ptr_next = is_insert ? held_reg : hi_reg;
        if (cmd.shift_wr) ptr_next = is_insert ? ptr_dn : ptr_up;
        if (cmd.finish) begin
            m_valid_next = 1'b1;
            out_next     = '0;
            if (is_insert && !full_reg && !eq_reg) begin
                held_next = held_reg + CNT_W'(1);
            end else if (is_erase && eq_reg) begin
                held_next = held_reg - CNT_W'(1);
            end else if (is_clear) begin
                held_next = '0;
            end
            priority if (is_insert) begin
                out_next.status = full_reg ? ST_FULL : (eq_reg ? ST_PRESENT : ST_DONE);
            end else if (is_erase) begin
                out_next.status = eq_reg ? ST_DONE : ST_ABSENT;
            end else if (is_find) begin
                out_next.status = eq_reg ? ST_DONE : ST_ABSENT;
                out_next.found  = eq_reg;
            end else if (is_access) begin
                out_next.status = slot_ok ? ST_DONE : ST_ABSENT;
                out_next.data   = slot_ok ? 32'(rdata_reg) : 32'd0;
            end else if (is_clear) begin
                out_next.status = ST_DONE;
            end else begin
                out_next.status = ST_ABSENT;
            end
            out_next.position = (is_find && eq_reg) ? 7'(hi_reg) : 7'(held_next);
            out_next.count    = 7'(held_next);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            held_reg    <= held_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_word.func;
            key_reg  <= KEY_WIDTH'(s_word.key);
            slot_reg <= s_word.slot;
            full_reg <= (held_reg >= cap_eff);
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        eq_reg  <= eq_next;
        ptr_reg <= ptr_next;
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

endmodule

>>> src/sorted_set_table.sv
// Sorted set table: a set of distinct unsigned keys held in ascending order.
// Top level; depends on sst_pkg, sst_ctrl and sst_dp.
//
// Usage:
//   The s_ channel carries one operation word (func, key, slot); the m_ channel
//   returns exactly one result word per operation, in order. Both channels use
//   valid/ready and a word moves when both are high.
//   The APB port holds one register, capacity, at byte address 0.
//   Write it only while no operation is in flight.
// Operation:
//   One operation is handled at a time. Find is a binary search over the n held
//   keys through the registered read of the single key store; insert and erase
//   then shift the keys past the search point one place up or down, and insert
//   writes its key last. Access reads one slot; clear, unused codes and an
//   insert into a full set go straight to the result. The controller returns
//   to its idle state before the next word is taken.
// Reset:
//   The set is empty and capacity reads 64; the key store is not cleared.
// Stalls:
//   The result waits in an output register while m_ready is low; the next
//   word is still taken and worked, and holds before its own result is posted.
module sorted_set_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sst_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output sst_pkg::out_word_t m_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sst_pkg::*;

    logic [6:0] capacity_reg, capacity_next;
    logic       cfg_wr;
    ctrl_cmd_t  cmd;
    ctrl_sts_t  sts;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == REG_CAPACITY);

    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_wr) capacity_next = pwdata[6:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    assign prdata = (paddr[2:2] == REG_CAPACITY) ? {25'd0, capacity_reg} : 32'd0;

    // Controller and datapath.
    sst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sst_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_word   (s_word),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word),
        .capacity (capacity_reg),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The count never passes the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_word.count) <= DEPTH))
        else $error("result count above store depth");

    // A located key is always a successful find.
    a_found_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_word.found) |-> (m_word.status == ST_DONE))
        else $error("found set without done status");

    // Nonzero read data only comes from a successful access.
    a_data_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_word.data != 32'd0)) |-> (m_word.status == ST_DONE))
        else $error("read data on a failed operation");

    // An accepted word closes the input until its work is done.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word taken while one is in flight");

endmodule

>>> bench/sorted_set_table_checker.sv
// Checker for the sorted set table: watches the operation, result and APB ports,
// predicts every result word and compares it with the block's output in order.
// Depends on sst_pkg for the word types, codes and store geometry.
`timescale 1ns / 100ps
module sorted_set_table_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  sst_pkg::in_word_t  s_word,
    input  logic               m_valid,
    input  logic               m_ready,
    input  sst_pkg::out_word_t m_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 mismatches,
    output int                 outstanding
);
    import sst_pkg::*;

    localparam logic [2:0] CAP_ADDR  = {REG_CAPACITY, 2'b00};
    localparam int         MAX_SHOWN = 40;

    // Shadow copy of the set and of the capacity register.
    key_t        key_store [DEPTH];
    int unsigned held_keys;
    logic [6:0]  cap_reg;

    // Result words predicted but not yet seen on the result port, oldest first.
    out_word_t   pending_results [$];
    out_word_t   want;
    int          errors;

    // First position whose key is not below k.
    function automatic int unsigned lower_bound(key_t k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = held_keys;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_store[mid] < k) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Applies one operation to the shadow set and returns its result word.
    function automatic out_word_t next_set_result(in_word_t w);
        out_word_t   r;
        key_t        k;
        int unsigned lim;
        int unsigned p;
        int unsigned i;
        bit          hit;
        bit          pos_done;
        r        = '0;
        k        = w.key[KEY_WIDTH-1:0];
        lim      = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        p        = lower_bound(k);
        hit      = (p < held_keys) && (key_store[p] == k);
        pos_done = 1'b0;
        r.status = ST_DONE;
        case (w.func)
            FUNC_INSERT: begin
                // A full set is reported before a duplicate key.
                if (held_keys >= lim || held_keys >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (hit) begin
                    r.status = ST_PRESENT;
                end else begin
                    for (i = held_keys; i > p; i--) begin
                        key_store[i] = key_store[i-1];
                    end
                    key_store[p] = k;
                    held_keys++;
                end
            end
            FUNC_ERASE: begin
                if (!hit) begin
                    r.status = ST_ABSENT;
                end else begin
                    for (i = p; i + 1 < held_keys; i++) begin
                        key_store[i] = key_store[i+1];
                    end
                    held_keys--;
                end
            end
            FUNC_FIND: begin
                if (hit) begin
                    r.found    = 1'b1;
                    r.position = 7'(p);
                    pos_done   = 1'b1;
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            FUNC_ACCESS: begin
                if (w.slot < held_keys) begin
                    r.data = 32'(key_store[w.slot]);
                end else begin
                    r.status = ST_ABSENT;
                end
            end
            FUNC_CLEAR: begin
                held_keys = 0;
            end
            default: begin
                // Unused operation codes change nothing.
                r.status = ST_ABSENT;
            end
        endcase
        if (!pos_done) begin
            r.position = 7'(held_keys);
        end
        r.count = 7'(held_keys);
        return r;
    endfunction

    // Compares one field and reports a difference.
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                         exp_v, got_v);
            end
        end
    endtask

    // Result words are checked before the word taken at the same edge is predicted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_results.delete();
            held_keys = 0;
            cap_reg   = CAP_RESET;
            errors    = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN) begin
                        $display("%0t: result word with none expected, expected nothing, actual %h",
                                 $time, m_word);
                    end
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_word.status));
                    check_field("found", 32'(want.found), 32'(m_word.found));
                    check_field("position", 32'(want.position), 32'(m_word.position));
                    check_field("data", want.data, m_word.data);
                    check_field("count", 32'(want.count), 32'(m_word.count));
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(next_set_result(s_word));
            end
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
                cap_reg = pwdata[6:0];
            end
        end
        outstanding <= pending_results.size();
        mismatches  <= errors;
    end

endmodule

>>> bench/sorted_set_table_tb.sv
// Top of the sorted set table testbench: clock, reset, operation and APB stimulus,
// result back-pressure and the verdict. Depends on sst_pkg, sorted_set_table
// and sorted_set_table_checker.
`timescale 1ns / 100ps
module sorted_set_table_tb;
    import sst_pkg::*;

    localparam int         CLK_PERIOD   = 20;
    localparam int         LIMIT_CYCLES = 1_000_000;
    localparam logic [2:0] CAP_ADDR     = {REG_CAPACITY, 2'b00};

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_word_t    s_word;
    logic        m_valid;
    logic        m_ready;
    out_word_t   m_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;

    // Set for the last part of the run, where neither side idles.
    bit          quiet;
    // Keys offered for insertion, reused so that finds and erases hit.
    logic [31:0] used_keys [$];

    sorted_set_table u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    sorted_set_table_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAILURE");
        $finish;
    end

    // Result back-pressure: stall bursts between stretches of steady acceptance.
    initial begin : ready_gen
        int n;
        m_ready = 1'b0;
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 12);
            end else begin
                m_ready <= 1'b1;
                n = $urandom_range(1, 24);
            end
            repeat (n) @(posedge aclk);
        end
    end

    // Offers one word, sometimes after a gap, and returns at the edge it is taken.
    // Valid is left high so that a following word needs no second assignment.
    task automatic send_word(input in_word_t w);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_op(input logic [2:0] func, input logic [31:0] key,
                           input logic [5:0] slot);
        in_word_t w;
        w.func = func;
        w.key  = key;
        w.slot = slot;
        send_word(w);
    endtask

    // Stops sending and waits until every predicted result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // APB write of the capacity register: setup cycle, then access cycle.
    task automatic write_capacity(input logic [6:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {25'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly keys seen before or from a narrow range, some at the extremes and some wide.
    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && used_keys.size() > 0) begin
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        end else if (r < 75) begin
            return $urandom_range(0, 200);
        end else if (r < 82) begin
            return $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
                                        : 32'($urandom_range(0, 3));
        end
        return $urandom();
    endfunction

    // One random phase under a given capacity.
    task automatic run_phase(input logic [6:0] cap, input int items, input int ins_pct,
                             input int clr_pct);
        in_word_t w;
        int       k;
        int       r;
        drain();
        write_capacity(cap);
        for (k = 0; k < items; k++) begin
            r      = $urandom_range(0, 99);
            w.key  = pick_key();
            w.slot = $urandom_range(0, 1) ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(0, 15));
            if (r < ins_pct) begin
                w.func = FUNC_INSERT;
                used_keys.push_back(w.key);
                if (used_keys.size() > 96) begin
                    void'(used_keys.pop_front());
                end
            end else if (r < ins_pct + clr_pct) begin
                w.func = FUNC_CLEAR;
            end else if (r < 97) begin
                case ($urandom_range(0, 2))
                    0:       w.func = FUNC_ERASE;
                    1:       w.func = FUNC_FIND;
                    default: w.func = FUNC_ACCESS;
                endcase
            end else begin
                // Unused operation codes.
                w.func = 3'($urandom_range(5, 7));
            end
            // Now and then let the block run dry before the next word.
            if (!quiet && $urandom_range(0, 199) == 0) begin
                drain();
            end
            send_word(w);
        end
    endtask

    // Main sequence.
    initial begin : stimulus
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        quiet   = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty set: every lookup misses.
        send_op(FUNC_FIND, 32'h0000_0000, 6'd0);
        send_op(FUNC_ERASE, 32'h0000_0000, 6'd0);
        send_op(FUNC_ACCESS, 32'h0000_0000, 6'd0);
        // Key extremes, inserted out of order, then a duplicate.
        send_op(FUNC_INSERT, 32'h0000_0000, 6'd0);
        send_op(FUNC_INSERT, 32'hFFFF_FFFF, 6'd63);
        send_op(FUNC_INSERT, 32'h8000_0000, 6'd0);
        send_op(FUNC_INSERT, 32'h7FFF_FFFF, 6'd0);
        send_op(FUNC_INSERT, 32'h8000_0000, 6'd0);
        // Finds at both ends and a miss.
        send_op(FUNC_FIND, 32'hFFFF_FFFF, 6'd0);
        send_op(FUNC_FIND, 32'h0000_0000, 6'd0);
        send_op(FUNC_FIND, 32'h1234_5678, 6'd0);
        // Access at both ends and past the count.
        send_op(FUNC_ACCESS, 32'h0000_0000, 6'd0);
        send_op(FUNC_ACCESS, 32'h0000_0000, 6'd3);
        send_op(FUNC_ACCESS, 32'h0000_0000, 6'd63);
        // Erase from the middle, again, then both ends.
        send_op(FUNC_ERASE, 32'h7FFF_FFFF, 6'd0);
        send_op(FUNC_ERASE, 32'h7FFF_FFFF, 6'd0);
        send_op(FUNC_ERASE, 32'h0000_0000, 6'd0);
        send_op(FUNC_ERASE, 32'hFFFF_FFFF, 6'd0);
        // Unused codes, then clear and a read of the emptied set.
        send_op(3'd5, 32'hFFFF_FFFF, 6'd63);
        send_op(3'd6, 32'h8000_0000, 6'd0);
        send_op(3'd7, 32'h0000_0001, 6'd1);
        send_op(FUNC_CLEAR, 32'h0000_0000, 6'd0);
        send_op(FUNC_ACCESS, 32'h0000_0000, 6'd0);
        // Zero capacity refuses every insert.
        drain();
        write_capacity(7'd0);
        send_op(FUNC_INSERT, 32'h0000_0005, 6'd0);

        // Random phases: balanced, fill past the store depth, capacity below the
        // held count, tiny capacities, a middle one, then a final run without idling.
        run_phase(7'd64, 500, 40, 2);
        run_phase(7'd127, 350, 70, 0);
        run_phase(7'd5, 150, 35, 1);
        run_phase(7'd0, 100, 40, 2);
        run_phase(7'd1, 150, 40, 3);
        run_phase(7'd20, 300, 45, 2);
        drain();
        quiet = 1'b1;
        run_phase(7'd64, 200, 45, 1);

        drain();
        repeat (150) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
